// ===== rtl/bsg_pkg.sv =====
// Package for the banknote splitter: widths, register indexes, reset values,
// queue entry types and the sequencer state type. No dependencies.
package bsg_pkg;

	localparam int AMOUNT_W = 20;
	localparam int DENOM_W = 16;
	localparam int IDX_W = 3;
	localparam int REG_IDX_W = 3;
	localparam int MAX_DENOMS_DEF = 6;
	localparam int REQ_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	localparam logic [IDX_W-1:0] DENOM_COUNT_RESET = 3'd1;
	localparam logic [DENOM_W-1:0] DENOM0_RESET = 16'd100;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DENOM_COUNT = 3'd0,
		REG_DENOM_0 = 3'd1,
		REG_DENOM_1 = 3'd2,
		REG_DENOM_2 = 3'd3,
		REG_DENOM_3 = 3'd4,
		REG_DENOM_4 = 3'd5,
		REG_DENOM_5 = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [AMOUNT_W-1:0] amount;
		logic [IDX_W-1:0] n;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0] denom_index;
		logic [AMOUNT_W-1:0] note_count;
		logic [AMOUNT_W-1:0] amount_left;
		logic last;
	} res_t;

	typedef struct packed {
		logic start;
		logic [AMOUNT_W-1:0] dividend;
		logic [DENOM_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [AMOUNT_W-1:0] quotient;
		logic [DENOM_W-1:0] remainder;
	} div_res_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_PUSH
	} st_t;

endpackage

// ===== rtl/bsg_fifo.sv =====
// Small register queue used between the front and back parts and at the
// result side. No package dependencies.
module bsg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign full = (cnt_q == DEPTH_CNT);
	assign empty = (cnt_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/bsg_front.sv =====
// Front part: configuration registers, request intake and classification.
// Depends on bsg_pkg and bsg_fifo.
module bsg_front #(
	parameter int MAX_DENOMS = bsg_pkg::MAX_DENOMS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        cfg_we,
	input  logic [bsg_pkg::REG_IDX_W-1:0]               cfg_index,
	input  logic [bsg_pkg::DENOM_W-1:0]                 cfg_data,
	input  logic                                        push,
	output logic                                        full,
	input  logic [bsg_pkg::AMOUNT_W-1:0]                amount,
	output logic [MAX_DENOMS-1:0][bsg_pkg::DENOM_W-1:0] denoms,
	input  logic                                        req_pop,
	output logic                                        req_empty,
	output bsg_pkg::req_t                               req
);

	import bsg_pkg::*;

	localparam logic [IDX_W-1:0] MAX_N = IDX_W'(MAX_DENOMS);

	logic [IDX_W-1:0] denom_count_q;
	logic [MAX_DENOMS-1:0][DENOM_W-1:0] denoms_q;
	logic [IDX_W-1:0] n_eff;
	logic req_push;
	req_t req_in;
	logic [$bits(req_t)-1:0] req_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			denom_count_q <= DENOM_COUNT_RESET;
		end else if (cfg_we && cfg_index == REG_DENOM_COUNT) begin
			denom_count_q <= cfg_data[IDX_W-1:0];
		end
	end

	for (genvar i = 0; i < MAX_DENOMS; i++) begin : g_denom
		localparam logic [REG_IDX_W-1:0] MY_IDX = REG_IDX_W'(int'(REG_DENOM_0) + i);
		localparam logic [DENOM_W-1:0] MY_RESET = (i == 0) ? DENOM0_RESET : '0;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				denoms_q[i] <= MY_RESET;
			end else if (cfg_we && cfg_index == MY_IDX) begin
				denoms_q[i] <= cfg_data;
			end
		end
	end

	assign denoms = denoms_q;

	// Requests with no note values in use produce no results and are dropped here.
	assign n_eff = (denom_count_q > MAX_N) ? MAX_N : denom_count_q;
	assign req_push = push && !full && (n_eff != '0);
	assign req_in = '{amount: amount, n: n_eff};
	assign req = req_t'(req_raw);

	bsg_fifo #(
		.WIDTH($bits(req_t)),
		.DEPTH(REQ_DEPTH)
	) u_req_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (req_push),
		.wdata (req_in),
		.full  (full),
		.rd_en (req_pop),
		.rdata (req_raw),
		.empty (req_empty)
	);

endmodule

// ===== rtl/bsg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the back part.
// Depends on bsg_pkg.
module bsg_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bsg_pkg::div_req_t   div_req,
	output bsg_pkg::div_res_t   div_res
);

	import bsg_pkg::*;

	localparam int STEP_W = $clog2(AMOUNT_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(AMOUNT_W - 1);

	logic busy_q;
	logic done_q;
	logic [STEP_W-1:0] step_q;
	logic [AMOUNT_W-1:0] quo_q;
	logic [DENOM_W-1:0] rem_q;
	logic [DENOM_W-1:0] dvs_q;
	logic [DENOM_W:0] shifted;
	logic [DENOM_W:0] diff;
	logic ge;

	assign shifted = {rem_q, quo_q[AMOUNT_W-1]};
	assign ge = (shifted >= {1'b0, dvs_q});
	assign diff = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (div_req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_req.start) begin
			quo_q <= div_req.dividend;
			rem_q <= '0;
			dvs_q <= div_req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[AMOUNT_W-2:0], ge};
			rem_q <= ge ? diff[DENOM_W-1:0] : shifted[DENOM_W-1:0];
		end
	end

	assign div_res = '{done: done_q, quotient: quo_q, remainder: rem_q};

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");

endmodule

// ===== rtl/bsg_back.sv =====
// Back part: walks the note values of one request, divides, holds back a
// note where needed and queues the results. Depends on bsg_pkg, bsg_div, bsg_fifo.
module bsg_back #(
	parameter int MAX_DENOMS = bsg_pkg::MAX_DENOMS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [MAX_DENOMS-1:0][bsg_pkg::DENOM_W-1:0] denoms,
	output logic                                        req_pop,
	input  logic                                        req_empty,
	input  bsg_pkg::req_t                               req,
	input  logic                                        pop,
	output logic                                        empty,
	output bsg_pkg::res_t                               res
);

	import bsg_pkg::*;

	st_t state_q;
	st_t state_d;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] n_q;
	logic [AMOUNT_W-1:0] left_q;
	res_t res_q;
	logic [DENOM_W-1:0] denom_sel;
	logic is_last;
	logic res_full;
	logic res_push;
	div_req_t div_req;
	div_res_t div_res;
	logic hold;
	logic [AMOUNT_W-1:0] cnt_adj;
	logic [AMOUNT_W-1:0] left_adj;
	logic [$bits(res_t)-1:0] res_raw;

	always_comb begin
		denom_sel = '0;
		for (int i = 0; i < MAX_DENOMS; i++) begin
			if (idx_q == IDX_W'(i)) begin
				denom_sel = denoms[i];
			end
		end
	end

	assign is_last = (idx_q == n_q - 1'b1);

	// A note is held back when the remainder is one or three and the count is nonzero.
	assign hold = (div_res.remainder == DENOM_W'(1) || div_res.remainder == DENOM_W'(3))
		&& (div_res.quotient != '0);
	assign cnt_adj = hold ? div_res.quotient - 1'b1 : div_res.quotient;
	assign left_adj = hold
		? AMOUNT_W'({1'b0, div_res.remainder} + {1'b0, denom_sel})
		: AMOUNT_W'(div_res.remainder);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!req_empty) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				state_d = (denom_sel == '0) ? ST_PUSH : ST_DIV;
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (!res_full) begin
					state_d = is_last ? ST_IDLE : ST_START;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_pop = 1'b0;
		res_push = 1'b0;
		div_req = '{start: 1'b0, dividend: left_q, divisor: denom_sel};
		case (state_q)
			ST_IDLE: begin
				req_pop = !req_empty;
			end
			ST_START: begin
				div_req.start = (denom_sel != '0);
			end
			ST_PUSH: begin
				res_push = !res_full;
			end
			default: begin
				req_pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			n_q <= '0;
		end else begin
			state_q <= state_d;
			if (req_pop) begin
				idx_q <= '0;
				n_q <= req.n;
			end else if (res_push && !is_last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_pop) begin
			left_q <= req.amount;
		end else if (state_q == ST_START && denom_sel == '0) begin
			res_q <= '{denom_index: idx_q, note_count: '0, amount_left: left_q,
				last: is_last};
		end else if (state_q == ST_DIV && div_res.done) begin
			left_q <= left_adj;
			res_q <= '{denom_index: idx_q, note_count: cnt_adj, amount_left: left_adj,
				last: is_last};
		end
	end

	bsg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.div_req(div_req),
		.div_res(div_res)
	);

	bsg_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.wr_en (res_push),
		.wdata (res_q),
		.full  (res_full),
		.rd_en (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign res = res_t'(res_raw);

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (idx_q < n_q))
		else $error("note index beyond the request count");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> (div_req.divisor != '0))
		else $error("division started with a zero note value");

	a_left_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_res.done) |=> (left_q <= $past(left_q)))
		else $error("amount left grew after a division");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && is_last) |=> (state_q == ST_IDLE))
		else $error("sequencer kept running after the last note value");

endmodule

// ===== rtl/banknote_split_greedy.sv =====
// Each note value of a request is divided in the one-bit-per-cycle divider shared by all
// note values; a note value of zero skips the divider. A new request is taken only after
// the last result of the previous one has been queued.
// Two requests and two results are queued, so the input stays open while results wait.
// Reset clears both queues and the sequencer; denom_count returns to 1, denom_0 to 100
// and the other note values to 0.
module banknote_split_greedy #(
	parameter int MAX_DENOMS = bsg_pkg::MAX_DENOMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bsg_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bsg_pkg::DENOM_W-1:0]   cfg_data,
	input  logic                          push,
	output logic                          full,
	input  logic [bsg_pkg::AMOUNT_W-1:0]  amount,
	output logic                          empty,
	input  logic                          pop,
	output logic [bsg_pkg::IDX_W-1:0]     denom_index,
	output logic [bsg_pkg::AMOUNT_W-1:0]  note_count,
	output logic [bsg_pkg::AMOUNT_W-1:0]  amount_left,
	output logic                          last
);

	import bsg_pkg::*;

	logic [MAX_DENOMS-1:0][DENOM_W-1:0] denoms;
	logic req_pop;
	logic req_empty;
	req_t req;
	res_t res;

	bsg_front #(
		.MAX_DENOMS(MAX_DENOMS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.push     (push),
		.full     (full),
		.amount   (amount),
		.denoms   (denoms),
		.req_pop  (req_pop),
		.req_empty(req_empty),
		.req      (req)
	);

	bsg_back #(
		.MAX_DENOMS(MAX_DENOMS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.denoms   (denoms),
		.req_pop  (req_pop),
		.req_empty(req_empty),
		.req      (req),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign denom_index = res.denom_index;
	assign note_count = res.note_count;
	assign amount_left = res.amount_left;
	assign last = res.last;

endmodule

// ===== test/tb_banknote_split_greedy.sv =====
// Self-checking testbench for banknote_split_greedy: queue-style stimulus with bursty pushes
// and patterned pops, checked against an in-bench model of the greedy note split.
// Depends on rtl/bsg_pkg.sv and rtl/banknote_split_greedy.sv.
`timescale 1ns / 100ps

module tb_banknote_split_greedy;
	import bsg_pkg::*;

	localparam int MAX_NOTES = MAX_DENOMS_DEF;
	localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam int SETTLE_CYCLES = 330;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int MAX_PRINTS = 40;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DENOM_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [AMOUNT_W-1:0] amount = '0;
	logic empty;
	logic pop = 1'b0;
	logic [IDX_W-1:0] denom_index;
	logic [AMOUNT_W-1:0] note_count;
	logic [AMOUNT_W-1:0] amount_left;
	logic last;

	logic [AMOUNT_W-1:0] pending_amounts[$];
	res_t expected_notes[$];
	logic [IDX_W-1:0] cfg_count = DENOM_COUNT_RESET;
	logic [DENOM_W-1:0] cfg_value[MAX_NOTES];
	logic [DENOM_W-1:0] note_plan[MAX_NOTES];
	res_t got;
	res_t want;
	int mismatches = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_phase = 0;
	logic [15:0] stall_pattern = 16'hFFFF;
	int idle_cycles = 0;

	banknote_split_greedy dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.amount(amount),
		.empty(empty),
		.pop(pop),
		.denom_index(denom_index),
		.note_count(note_count),
		.amount_left(amount_left),
		.last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Greedy split with the hold-back rule: a remainder of 1 or 3 gives one note back when the count is nonzero.
	function automatic void predict_split(input logic [AMOUNT_W-1:0] amt);
		logic [AMOUNT_W-1:0] left;
		logic [AMOUNT_W-1:0] cnt;
		logic [AMOUNT_W-1:0] d;
		int n;
		res_t r;
		left = amt;
		n = (int'(cfg_count) > MAX_NOTES) ? MAX_NOTES : int'(cfg_count);
		for (int i = 0; i < n; i++) begin
			d = AMOUNT_W'(cfg_value[i]);
			cnt = '0;
			if (d != '0) begin
				cnt = left / d;
				left = left % d;
				if ((left == 20'd1 || left == 20'd3) && cnt != '0) begin
					cnt = cnt - 20'd1;
					left = left + d;
				end
			end
			r.denom_index = IDX_W'(i);
			r.note_count = cnt;
			r.amount_left = left;
			r.last = (i + 1 == n);
			expected_notes.push_back(r);
		end
	endfunction

	function automatic logic [AMOUNT_W-1:0] pick_amount();
		logic [31:0] d;
		logic [31:0] v;
		d = 32'(cfg_value[$urandom_range(0, MAX_NOTES - 1)]);
		if (d == 0)
			d = 32'd100;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 1000);
			1: v = $urandom;
			2: v = d * $urandom_range(1, 1048572 / d) + (($urandom_range(0, 1) == 1) ? 1 : 3);
			3: v = ($urandom_range(0, 1) == 1) ? 32'hFFFFF : 32'd0;
			4: v = $urandom_range(0, 15);
			default: v = $urandom_range(0, 200000);
		endcase
		return v[AMOUNT_W-1:0];
	endfunction

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DENOM_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DENOM_COUNT)
			cfg_count = data[IDX_W-1:0];
		else if (idx >= REG_DENOM_0 && idx <= REG_DENOM_5)
			cfg_value[int'(idx) - int'(REG_DENOM_0)] = data;
	endtask

	task automatic load_plan(input logic [DENOM_W-1:0] count_word);
		write_reg(REG_DENOM_COUNT, count_word);
		for (int i = 0; i < MAX_NOTES; i++)
			write_reg(REG_IDX_W'(int'(REG_DENOM_0) + i), note_plan[i]);
	endtask

	// Every queued amount transferred and every result seen, then time for
	// requests that produce no result to leave the block.
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_amounts.size() != 0 || expected_notes.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Sender: bursts of random length separated by random gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else if (gap_left > 0) begin
			push <= 1'b0;
			amount <= AMOUNT_W'($urandom);
			gap_left--;
		end else begin
			push <= (pending_amounts.size() != 0);
			amount <= (pending_amounts.size() != 0) ? pending_amounts[0] : AMOUNT_W'($urandom);
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			end
		end
	end

	// Receiver: pops follow a repeating 16-bit pattern, with a new pattern drawn at the end of each phase.
	always @(negedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (stall_phase == 0) begin
				case ($urandom_range(0, 3))
					0: stall_pattern = 16'hFFFF;
					1: stall_pattern = 16'($urandom & $urandom) | 16'h0001;
					default: stall_pattern = 16'($urandom) | 16'h0001;
				endcase
				stall_phase = 64;
			end
			stall_phase--;
			pop <= stall_pattern[stall_phase % 16];
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				got.denom_index = denom_index;
				got.note_count = note_count;
				got.amount_left = amount_left;
				got.last = last;
				if (expected_notes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_PRINTS)
						$display("%0t: unexpected result: index %0d count %0d left %0d last %0d",
							$time, got.denom_index, got.note_count, got.amount_left, got.last);
				end else begin
					want = expected_notes.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= MAX_PRINTS)
							$display({"%0t: mismatch: expected index %0d count %0d left %0d last %0d,",
								" actual index %0d count %0d left %0d last %0d"}, $time,
								want.denom_index, want.note_count, want.amount_left, want.last,
								got.denom_index, got.note_count, got.amount_left, got.last);
					end
				end
			end
			if (push && !full) begin
				predict_split(amount);
				pending_amounts.delete(0);
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("banknote_split_greedy regression: fail");
				$finish;
			end
		end
	end

	initial begin
		for (int i = 0; i < MAX_NOTES; i++)
			cfg_value[i] = '0;
		cfg_value[0] = DENOM0_RESET;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// Values after reset: a single note value of 100.
		@(posedge clk);
		pending_amounts.push_back(20'd0);
		pending_amounts.push_back(20'd1);
		pending_amounts.push_back(20'd100);
		pending_amounts.push_back(20'd101);
		pending_amounts.push_back(20'd103);
		pending_amounts.push_back(20'hFFFFF);
		wait_idle();

		// Typical table where remainders of 1 and 3 force notes to be held back.
		note_plan[0] = 16'd100;
		note_plan[1] = 16'd50;
		note_plan[2] = 16'd20;
		note_plan[3] = 16'd10;
		note_plan[4] = 16'd5;
		note_plan[5] = 16'd2;
		load_plan(16'd6);
		@(posedge clk);
		pending_amounts.push_back(20'd1);
		pending_amounts.push_back(20'd3);
		pending_amounts.push_back(20'd4);
		pending_amounts.push_back(20'd6);
		pending_amounts.push_back(20'd8);
		pending_amounts.push_back(20'd23);
		pending_amounts.push_back(20'd188);
		pending_amounts.push_back(20'd1048573);
		wait_idle();

		// Extreme note values including zero, with a count above the maximum.
		note_plan[0] = 16'hFFFF;
		note_plan[1] = 16'd0;
		note_plan[2] = 16'd1;
		note_plan[3] = 16'hFFFF;
		note_plan[4] = 16'd0;
		note_plan[5] = 16'd2;
		load_plan(16'hA5A7);
		@(posedge clk);
		pending_amounts.push_back(20'd0);
		pending_amounts.push_back(20'd65536);
		pending_amounts.push_back(20'd65538);
		pending_amounts.push_back(20'hFFFFF);
		wait_idle();

		// A count of zero gives no results at all.
		write_reg(REG_DENOM_COUNT, 16'hFFF8);
		@(posedge clk);
		pending_amounts.push_back(20'd5);
		pending_amounts.push_back(20'hFFFFF);
		wait_idle();

		// A write beyond the register list must leave the table untouched.
		write_reg(REG_UNMAPPED, 16'hFFFF);
		write_reg(REG_DENOM_COUNT, 16'd6);
		@(posedge clk);
		pending_amounts.push_back(20'd70000);
		pending_amounts.push_back(20'd3);
		wait_idle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if ($urandom_range(0, 2) != 0) begin
				note_plan[0] = ($urandom_range(0, 1) == 1) ? 16'($urandom_range(2, 500))
					: 16'($urandom_range(1, 65535));
				for (int i = 1; i < MAX_NOTES; i++)
					note_plan[i] = note_plan[i-1] / 16'($urandom_range(2, 5));
			end else begin
				for (int i = 0; i < MAX_NOTES; i++)
					note_plan[i] = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
			end
			load_plan(16'($urandom & 32'hFFF8) | 16'($urandom_range(1, 7)));
			@(posedge clk);
			for (int k = 0; k < PHASE_ITEMS; k++)
				pending_amounts.push_back(pick_amount());
			wait_idle();
		end

		if (mismatches == 0)
			$display("banknote_split_greedy regression: pass");
		else
			$display("banknote_split_greedy regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bsg_pkg.sv
rtl/bsg_fifo.sv
rtl/bsg_front.sv
rtl/bsg_div.sv
rtl/bsg_back.sv
rtl/banknote_split_greedy.sv
test/tb_banknote_split_greedy.sv
